// ===== design/srg_pkg.sv =====
// Shared types, constants and helpers for the stepper ramp generator.
// No dependencies; every other design file uses this package.
package srg_pkg;

    localparam int FRAC_BITS = 8;
    localparam int Q_W       = 32;
    localparam int POS_W     = 32;
    localparam int RAMP_W    = 16;
    localparam int CRUISE_W  = 20;
    localparam int HIGH_W    = 8;
    localparam int STALL_W   = 16;

    // serial multiply/divide unit
    localparam int MUL_W   = RAMP_W + 2;
    localparam int PROD_W  = Q_W + MUL_W;
    localparam int DIGIT   = 2;
    localparam int MUL_CYC = MUL_W / DIGIT;
    localparam int DIV_CYC = Q_W / DIGIT;
    localparam int CYC_MAX = (MUL_CYC > DIV_CYC) ? MUL_CYC : DIV_CYC;
    localparam int CNT_W   = $clog2(CYC_MAX);

    // cruise entry test: period * 200 <= cruise_q * 201
    localparam int CQ_W       = CRUISE_W + FRAC_BITS;
    localparam int THR_W      = ((Q_W > CQ_W) ? Q_W : CQ_W) + 8;
    localparam int THR_PERIOD = 200;
    localparam int THR_CRUISE = 201;

    // first-step factor 0.676 = 507 / 750, folded as 507 / 1250 with the (4n-1)/(4n+1) term
    localparam logic [MUL_W-1:0] FIRST_NUM = MUL_W'(507);
    localparam logic [MUL_W-1:0] FIRST_DEN = MUL_W'(1250);

    localparam logic [Q_W-1:0]    ONE_Q    = Q_W'(1) << FRAC_BITS;
    localparam logic [RAMP_W-1:0] RAMP_MAX = '1;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_MOVE = 1'b1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_TIME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL     = 2'd2;

    localparam logic [HIGH_W-1:0]  HIGH_TIME_RST = HIGH_W'(3);
    localparam logic [STALL_W-1:0] STALL_RST     = STALL_W'(1000);

    typedef enum logic [1:0] {
        PH_ACCEL,
        PH_CRUISE,
        PH_BRAKE
    } phase_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_CHK,
        MD_DIV
    } md_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE,
        ST_RATE,
        ST_WAIT,
        ST_FIN
    } ctl_state_t;

    typedef struct packed {
        logic               enable;
        logic [HIGH_W-1:0]  high_time;
        logic [STALL_W-1:0] stall_period;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [Q_W-1:0]   mcand;
        logic [MUL_W-1:0] mplier;
        logic [MUL_W-1:0] divisor;
    } md_req_t;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quo;
    } md_rsp_t;

    // whole microseconds to Q form, saturating
    function automatic logic [Q_W-1:0] to_q(input logic [Q_W-1:0] whole);
        logic [Q_W+FRAC_BITS-1:0] w;
        w = {whole, {FRAC_BITS{1'b0}}};
        if (|w[Q_W+FRAC_BITS-1:Q_W])
            return '1;
        return w[Q_W-1:0];
    endfunction

endpackage

// ===== design/srg_ifs.sv =====
// Valid/ready channel interfaces: move/tick items, result beats, config writes.
// Depends on srg_pkg.
interface srg_in_if;
    logic                              valid;
    logic                              ready;
    logic                              op;
    logic signed [srg_pkg::POS_W-1:0]  goal;
    logic [srg_pkg::CRUISE_W-1:0]      min_period;

    modport source (output valid, op, goal, min_period, input ready);
    modport sink   (input valid, op, goal, min_period, output ready);
endinterface

interface srg_out_if;
    logic                              valid;
    logic                              ready;
    logic                              step_pin;
    logic                              dir_pin;
    logic signed [srg_pkg::POS_W-1:0]  position;
    logic                              busy_res;

    modport source (output valid, step_pin, dir_pin, position, busy_res, input ready);
    modport sink   (input valid, step_pin, dir_pin, position, busy_res, output ready);
endinterface

interface srg_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [srg_pkg::CFG_IDX_W-1:0]      index;
    logic [srg_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/srg_cfg.sv =====
// Configuration register file: enable, step high time, stall period.
// Depends on srg_pkg and srg_cfg_if.
module srg_cfg (
    input  logic            clk,
    input  logic            rst_n,
    srg_cfg_if.sink         cfg,
    output srg_pkg::cfg_t   regs
);

    srg_pkg::cfg_t regs_reg;
    srg_pkg::cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                srg_pkg::CFG_ENABLE:    regs_next.enable       = cfg.data[0];
                srg_pkg::CFG_HIGH_TIME: regs_next.high_time    = cfg.data[srg_pkg::HIGH_W-1:0];
                srg_pkg::CFG_STALL:     regs_next.stall_period = cfg.data[srg_pkg::STALL_W-1:0];
                default:                regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.enable       <= 1'b0;
            regs_reg.high_time    <= srg_pkg::HIGH_TIME_RST;
            regs_reg.stall_period <= srg_pkg::STALL_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ===== design/srg_muldiv.sv =====
// Digit-serial unit: quotient = sat32(mcand * mplier / divisor), two bits per cycle.
// Shift-add multiply, overflow check, then restoring divide. Depends on srg_pkg.
module srg_muldiv (
    input  logic              clk,
    input  logic              rst_n,
    input  srg_pkg::md_req_t  req,
    output srg_pkg::md_rsp_t  rsp
);

    srg_pkg::md_state_t                state_reg, state_next;
    logic [srg_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic                              done_reg, done_next;
    logic [srg_pkg::PROD_W-1:0]        prod_reg, prod_next;
    logic [srg_pkg::MUL_W-1:0]         rem_reg, rem_next;
    logic [srg_pkg::Q_W-1:0]           mcand_reg, mcand_next;
    logic [srg_pkg::MUL_W-1:0]         div_reg, div_next;

    assign rsp.done = done_reg;
    assign rsp.quo  = prod_reg[srg_pkg::Q_W-1:0];

    always_comb
    begin
        logic [srg_pkg::PROD_W-1:0] p;
        logic [srg_pkg::Q_W:0]      sum;
        logic [srg_pkg::MUL_W-1:0]  r;
        logic [srg_pkg::Q_W-1:0]    d;
        logic [srg_pkg::MUL_W:0]    t;
        logic [srg_pkg::MUL_W:0]    diff;

        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        mcand_next = mcand_reg;
        div_next   = div_reg;
        p          = prod_reg;
        sum        = '0;
        r          = rem_reg;
        d          = prod_reg[srg_pkg::Q_W-1:0];
        t          = '0;
        diff       = '0;

        unique case (state_reg)
            srg_pkg::MD_IDLE:
            begin
                if (req.start)
                begin
                    mcand_next = req.mcand;
                    div_next   = req.divisor;
                    prod_next  = {{srg_pkg::Q_W{1'b0}}, req.mplier};
                    cnt_next   = srg_pkg::CNT_W'(srg_pkg::MUL_CYC - 1);
                    state_next = srg_pkg::MD_MUL;
                end
            end
            srg_pkg::MD_MUL:
            begin
                for (int i = 0; i < srg_pkg::DIGIT; i++)
                begin
                    sum = {1'b0, p[srg_pkg::PROD_W-1:srg_pkg::MUL_W]}
                        + {1'b0, (p[0] ? mcand_reg : {srg_pkg::Q_W{1'b0}})};
                    p   = {sum, p[srg_pkg::MUL_W-1:1]};
                end
                prod_next = p;
                if (cnt_reg == '0)
                    state_next = srg_pkg::MD_CHK;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            srg_pkg::MD_CHK:
            begin
                if (prod_reg[srg_pkg::PROD_W-1:srg_pkg::Q_W] >= div_reg)
                begin
                    prod_next[srg_pkg::Q_W-1:0] = '1;
                    done_next  = 1'b1;
                    state_next = srg_pkg::MD_IDLE;
                end
                else
                begin
                    rem_next   = prod_reg[srg_pkg::PROD_W-1:srg_pkg::Q_W];
                    cnt_next   = srg_pkg::CNT_W'(srg_pkg::DIV_CYC - 1);
                    state_next = srg_pkg::MD_DIV;
                end
            end
            srg_pkg::MD_DIV:
            begin
                for (int i = 0; i < srg_pkg::DIGIT; i++)
                begin
                    t    = {r, d[srg_pkg::Q_W-1]};
                    d    = {d[srg_pkg::Q_W-2:0], 1'b0};
                    diff = t - {1'b0, div_reg};
                    if (t >= {1'b0, div_reg})
                    begin
                        r    = diff[srg_pkg::MUL_W-1:0];
                        d[0] = 1'b1;
                    end
                    else
                    begin
                        r = t[srg_pkg::MUL_W-1:0];
                    end
                end
                rem_next                    = r;
                prod_next[srg_pkg::Q_W-1:0] = d;
                if (cnt_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = srg_pkg::MD_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = srg_pkg::MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srg_pkg::MD_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        rem_reg   <= rem_next;
        mcand_reg <= mcand_next;
        div_reg   <= div_next;
    end

endmodule

// ===== design/stepper_ramp_generator_unit.sv =====
// Single-axis step pulse generator with trapezoidal ramp (top level).
// Depends on srg_pkg, srg_ifs, srg_cfg and srg_muldiv.
//
// Each item beat is a one-microsecond tick or a move command, and each gives one
// result beat with the step pin, direction, position and busy flag. A move, or a
// tick that counts down, raises the pin or is ignored, is done in the idle state.
// A tick that drops the pin runs the next-period update through ST_EDGE, ST_RATE
// and ST_FIN when the period is simply set, and with ST_WAIT before ST_FIN, while
// the serial multiply/divide unit runs, when it is ramped. One finished result can
// wait in the output register while the next item is taken; a second one holds off
// the item channel until the first is taken.
module stepper_ramp_generator_unit (
    input  logic        clk,
    input  logic        rst_n,
    srg_cfg_if.sink     cfg,
    srg_in_if.sink      item,
    srg_out_if.source   result
);

    srg_pkg::cfg_t      cfg_regs;
    srg_pkg::md_req_t   md_req;
    srg_pkg::md_rsp_t   md_rsp;

    srg_pkg::ctl_state_t            state_reg, state_next;
    logic [srg_pkg::POS_W-1:0]      cur_pos_reg, cur_pos_next;
    logic [srg_pkg::POS_W-1:0]      aim_pos_reg, aim_pos_next;
    srg_pkg::phase_t                phase_reg, phase_next;
    logic [srg_pkg::RAMP_W-1:0]     ramp_reg, ramp_next;
    logic [srg_pkg::Q_W-1:0]        period_reg, period_next;
    logic [srg_pkg::CRUISE_W-1:0]   cruise_reg, cruise_next;
    logic [srg_pkg::Q_W-1:0]        time_left_reg, time_left_next;
    logic                           pin_reg, pin_next;
    logic                           heading_reg, heading_next;
    logic                           idle_reg, idle_next;
    logic                           pend_reg, pend_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           out_pin_reg, out_pin_next;
    logic                           out_dir_reg, out_dir_next;
    logic [srg_pkg::POS_W-1:0]      out_pos_reg, out_pos_next;
    logic                           out_busy_reg, out_busy_next;

    logic slot_free;
    logic accept;

    srg_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_regs)
    );

    srg_muldiv u_md (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    assign slot_free       = !out_valid_reg || result.ready;
    assign item.ready      = (state_reg == srg_pkg::ST_IDLE) && !pend_reg;
    assign accept          = item.valid && item.ready;
    assign result.valid    = out_valid_reg;
    assign result.step_pin = out_pin_reg;
    assign result.dir_pin  = out_dir_reg;
    assign result.position = $signed(out_pos_reg);
    assign result.busy_res = out_busy_reg;

    always_comb
    begin
        logic signed [srg_pkg::POS_W:0]   pos_x;
        logic signed [srg_pkg::POS_W:0]   old_d;
        logic signed [srg_pkg::POS_W:0]   new_d;
        logic signed [srg_pkg::POS_W:0]   head_d;
        logic signed [srg_pkg::POS_W:0]   diff;
        logic [srg_pkg::POS_W:0]          gap;
        logic                             farther;
        logic [srg_pkg::CRUISE_W-1:0]     start_p;
        logic [srg_pkg::POS_W-1:0]        aim_sel;
        logic [srg_pkg::THR_W-1:0]        thr_lhs;
        logic [srg_pkg::THR_W-1:0]        thr_rhs;
        srg_pkg::phase_t                  ph;
        logic [srg_pkg::RAMP_W-1:0]       rn;
        logic [srg_pkg::MUL_W-1:0]        n4;
        logic [srg_pkg::Q_W-1:0]          hq;
        logic [srg_pkg::Q_W-1:0]          cruise_q;
        logic                             done_item;

        state_next     = state_reg;
        cur_pos_next   = cur_pos_reg;
        aim_pos_next   = aim_pos_reg;
        phase_next     = phase_reg;
        ramp_next      = ramp_reg;
        period_next    = period_reg;
        cruise_next    = cruise_reg;
        time_left_next = time_left_reg;
        pin_next       = pin_reg;
        heading_next   = heading_reg;
        idle_next      = idle_reg;
        pend_next      = pend_reg;
        md_req         = '0;
        done_item      = 1'b0;

        pos_x    = $signed({cur_pos_reg[srg_pkg::POS_W-1], cur_pos_reg});
        old_d    = $signed({aim_pos_reg[srg_pkg::POS_W-1], aim_pos_reg}) - pos_x;
        new_d    = $signed({item.goal[srg_pkg::POS_W-1], item.goal}) - pos_x;
        head_d   = old_d;
        diff     = old_d;
        gap      = diff[srg_pkg::POS_W] ? $unsigned(-diff) : $unsigned(diff);
        farther  = 1'b0;
        start_p  = '0;
        aim_sel  = aim_pos_reg;
        thr_lhs  = srg_pkg::THR_W'(period_reg) * srg_pkg::THR_W'(srg_pkg::THR_PERIOD);
        thr_rhs  = srg_pkg::THR_W'({cruise_reg, {srg_pkg::FRAC_BITS{1'b0}}})
                 * srg_pkg::THR_W'(srg_pkg::THR_CRUISE);
        ph       = phase_reg;
        rn       = ramp_reg;
        n4       = '0;
        hq       = srg_pkg::to_q(srg_pkg::Q_W'(cfg_regs.high_time));
        cruise_q = srg_pkg::to_q(srg_pkg::Q_W'(cruise_reg));

        unique case (state_reg)
            srg_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.op == srg_pkg::OP_MOVE)
                    begin
                        farther = ((old_d > 0) && (new_d > 0) && (old_d < new_d))
                               || ((old_d < 0) && (new_d < 0) && (old_d > new_d));
                        ramp_next = '0;
                        if (idle_reg)
                        begin
                            start_p = (item.min_period > srg_pkg::CRUISE_W'(cfg_regs.stall_period))
                                    ? item.min_period
                                    : srg_pkg::CRUISE_W'(cfg_regs.stall_period);
                            period_next = srg_pkg::to_q(srg_pkg::Q_W'(start_p));
                            aim_sel     = item.goal;
                            phase_next  = srg_pkg::PH_ACCEL;
                            head_d      = new_d;
                        end
                        else if (farther)
                        begin
                            aim_sel    = item.goal;
                            phase_next = srg_pkg::PH_ACCEL;
                            head_d     = new_d;
                        end
                        aim_pos_next = aim_sel;
                        cruise_next  = item.min_period;
                        heading_next = !head_d[srg_pkg::POS_W];
                        if (aim_sel != cur_pos_reg)
                            idle_next = 1'b0;
                        done_item = 1'b1;
                    end
                    else if (!cfg_regs.enable || idle_reg)
                    begin
                        done_item = 1'b1;
                    end
                    else if (time_left_reg > srg_pkg::ONE_Q)
                    begin
                        time_left_next = time_left_reg - srg_pkg::ONE_Q;
                        done_item      = 1'b1;
                    end
                    else if (!pin_reg)
                    begin
                        pin_next       = 1'b1;
                        time_left_next = hq;
                        cur_pos_next   = heading_reg ? cur_pos_reg + srg_pkg::POS_W'(1)
                                                     : cur_pos_reg - srg_pkg::POS_W'(1);
                        done_item      = 1'b1;
                    end
                    else
                    begin
                        pin_next   = 1'b0;
                        state_next = srg_pkg::ST_EDGE;
                    end
                end
            end
            srg_pkg::ST_EDGE:
            begin
                if (gap < ((srg_pkg::POS_W+1)'(ramp_reg) + (srg_pkg::POS_W+1)'(1)))
                    phase_next = srg_pkg::PH_BRAKE;
                state_next = srg_pkg::ST_RATE;
            end
            srg_pkg::ST_RATE:
            begin
                state_next = srg_pkg::ST_FIN;
                if ((ph == srg_pkg::PH_ACCEL) && (thr_lhs <= thr_rhs))
                    ph = srg_pkg::PH_CRUISE;
                if (ph == srg_pkg::PH_ACCEL)
                begin
                    rn        = (ramp_reg == srg_pkg::RAMP_MAX) ? ramp_reg : ramp_reg + 1'b1;
                    ramp_next = rn;
                    n4        = {rn, 2'b00};
                    md_req.start = 1'b1;
                    md_req.mcand = period_reg;
                    if (rn == srg_pkg::RAMP_W'(1))
                    begin
                        md_req.mplier  = srg_pkg::FIRST_NUM;
                        md_req.divisor = srg_pkg::FIRST_DEN;
                    end
                    else
                    begin
                        md_req.mplier  = n4 - 1'b1;
                        md_req.divisor = n4 + 1'b1;
                    end
                    state_next = srg_pkg::ST_WAIT;
                end
                else if (ph == srg_pkg::PH_CRUISE)
                begin
                    period_next = cruise_q;
                end
                else
                begin
                    if (cur_pos_reg == aim_pos_reg)
                    begin
                        idle_next = 1'b1;
                        ph        = srg_pkg::PH_ACCEL;
                    end
                    else if (cruise_reg < srg_pkg::CRUISE_W'(cfg_regs.stall_period))
                    begin
                        rn        = (ramp_reg == '0) ? ramp_reg : ramp_reg - 1'b1;
                        ramp_next = rn;
                        n4        = {rn, 2'b00};
                        md_req.mcand = period_reg;
                        if (rn == srg_pkg::RAMP_W'(1))
                        begin
                            md_req.start   = 1'b1;
                            md_req.mplier  = srg_pkg::FIRST_DEN;
                            md_req.divisor = srg_pkg::FIRST_NUM;
                            state_next     = srg_pkg::ST_WAIT;
                        end
                        else if (rn > srg_pkg::RAMP_W'(1))
                        begin
                            md_req.start   = 1'b1;
                            md_req.mplier  = n4 + 1'b1;
                            md_req.divisor = n4 - 1'b1;
                            state_next     = srg_pkg::ST_WAIT;
                        end
                    end
                end
                phase_next = ph;
            end
            srg_pkg::ST_WAIT:
            begin
                if (md_rsp.done)
                begin
                    period_next = md_rsp.quo;
                    state_next  = srg_pkg::ST_FIN;
                end
            end
            srg_pkg::ST_FIN:
            begin
                time_left_next = (period_reg > hq) ? period_reg - hq : '0;
                done_item      = 1'b1;
                state_next     = srg_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = srg_pkg::ST_IDLE;
            end
        endcase

        // result beat: from the new state, or from a held one
        out_valid_next = (out_valid_reg && !result.ready) ? 1'b1 : 1'b0;
        out_pin_next   = out_pin_reg;
        out_dir_next   = out_dir_reg;
        out_pos_next   = out_pos_reg;
        out_busy_next  = out_busy_reg;
        if (done_item)
        begin
            if (slot_free)
            begin
                out_valid_next = 1'b1;
                out_pin_next   = pin_next;
                out_dir_next   = heading_next;
                out_pos_next   = cur_pos_next;
                out_busy_next  = !idle_next;
            end
            else
            begin
                pend_next = 1'b1;
            end
        end
        else if (pend_reg && slot_free)
        begin
            out_valid_next = 1'b1;
            out_pin_next   = pin_reg;
            out_dir_next   = heading_reg;
            out_pos_next   = cur_pos_reg;
            out_busy_next  = !idle_reg;
            pend_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srg_pkg::ST_IDLE;
            cur_pos_reg   <= '0;
            aim_pos_reg   <= '0;
            phase_reg     <= srg_pkg::PH_ACCEL;
            ramp_reg      <= '0;
            period_reg    <= '0;
            cruise_reg    <= '0;
            time_left_reg <= '0;
            pin_reg       <= 1'b0;
            heading_reg   <= 1'b1;
            idle_reg      <= 1'b1;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_pos_reg   <= cur_pos_next;
            aim_pos_reg   <= aim_pos_next;
            phase_reg     <= phase_next;
            ramp_reg      <= ramp_next;
            period_reg    <= period_next;
            cruise_reg    <= cruise_next;
            time_left_reg <= time_left_next;
            pin_reg       <= pin_next;
            heading_reg   <= heading_next;
            idle_reg      <= idle_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_pin_reg  <= out_pin_next;
        out_dir_reg  <= out_dir_next;
        out_pos_reg  <= out_pos_next;
        out_busy_reg <= out_busy_next;
    end

endmodule
